// ===== hdl/wildcard_glob_matcher_top_defines.svh =====
// Assertion macros shared by the glob matcher RTL.
`ifndef WILDCARD_GLOB_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition on every rising clock edge outside reset.
`define GLOB_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that an antecedent implies a consequent on the same edge.
`define GLOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define GLOB_ASSERT(lbl, clk, rst_n, cond, msg)
`define GLOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/wgm_pkg.sv =====
// Shared types and constants for the glob matcher.
package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 128;
  localparam int CHAR_W          = 8;

  localparam logic [CHAR_W-1:0] STAR_CODE  = 8'd42;
  localparam logic [CHAR_W-1:0] QMARK_CODE = 8'd63;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SUBJ   = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic              clear;
    logic              shift;
    logic              rearm;
    logic              step;
    logic [CHAR_W-1:0] ch;
  } wgm_ctrl_t;

endpackage

// ===== hdl/wgm_cell.sv =====
// One pattern cell: holds a character, its start marker and its active bit.
module wgm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wgm_pkg::wgm_ctrl_t        ctrl,
  input  logic [wgm_pkg::CHAR_W-1:0] prev_char,
  input  logic                      prev_first,
  input  logic                      move_in,
  input  logic                      fwd_in,
  output logic [wgm_pkg::CHAR_W-1:0] char_q,
  output logic                      first_q,
  output logic                      move_out,
  output logic                      fwd_out
);

  logic [wgm_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                       first_r, first_nxt;
  logic                       active_r, active_nxt;
  logic                       is_star, is_star_nxt, raw;

  // Shift the pattern toward the start on a stored append
  assign char_nxt  = ctrl.shift ? prev_char : char_r;
  assign first_nxt = ctrl.clear ? 1'b0 : (ctrl.shift ? prev_first : first_r);

  assign is_star     = (char_r == wgm_pkg::STAR_CODE);
  assign is_star_nxt = (char_nxt == wgm_pkg::STAR_CODE);

  // Advance past this character when it matches the subject character
  assign move_out = active_r & ~is_star &
                    ((char_r == wgm_pkg::QMARK_CODE) | (char_r == ctrl.ch));

  // Unclosed activity: start marker on rearm, otherwise star hold or arrival
  assign raw     = ctrl.rearm ? first_nxt : ((active_r & is_star) | move_in);
  assign fwd_out = raw & is_star_nxt;

  always_comb begin
    active_nxt = active_r;
    if (ctrl.rearm || ctrl.step) begin
      active_nxt = raw | fwd_in;
    end
  end

  // Hold character without reset; control bits clear on reset
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      first_r  <= first_nxt;
      active_r <= active_nxt;
    end
  end

  assign char_q  = char_r;
  assign first_q = first_r;

endmodule

// ===== hdl/wildcard_glob_matcher_top.sv =====
// Top level of the glob matcher: command decode, cell chain and result register.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_stall, in_op, in_char_code | request in
//   out     | out_valid, out_stall, out_matched,      | result out
//           | out_pattern_overflowed                  |
//
// One request is accepted per cycle while in_stall is low, set by the
// single-step update of the active bit in each cell of the chain.
// An end-of-subject request yields its result on the following cycle.
// Reset leaves an empty pattern, no overflow and only the end position active.
// in_stall rises only for an end-of-subject request while a result is held and stalled.
// Runs of stars are stored as one star, so closure spans one neighbor only.
`include "wildcard_glob_matcher_top_defines.svh"

module wildcard_glob_matcher_top #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [wgm_pkg::CHAR_W-1:0] in_char_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_matched,
  output logic                       out_pattern_overflowed
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  wgm_pkg::wgm_ctrl_t ctrl;

  logic                       in_acc;
  logic                       is_clear, is_append, is_subj, is_end;
  logic                       room, last_star, store;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       empty_r, empty_nxt;
  logic                       end_r, end_nxt, end_raw;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_matched_r, out_ovf_r;

  logic [wgm_pkg::CHAR_W-1:0] char_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     first_vec;
  logic [MAX_PATTERN:0]       move;
  logic [MAX_PATTERN:0]       fwd;

  // Accept unless a result request would overwrite a stalled result
  assign in_stall = out_valid_r & out_stall & (in_op == wgm_pkg::OP_END);
  assign in_acc   = in_valid & ~in_stall;

  // Decode the request code
  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_subj   = 1'b0;
    is_end    = 1'b0;
    unique case (in_op)
      wgm_pkg::OP_CLEAR:  is_clear  = in_acc;
      wgm_pkg::OP_APPEND: is_append = in_acc;
      wgm_pkg::OP_SUBJ:   is_subj   = in_acc;
      wgm_pkg::OP_END:    is_end    = in_acc;
      default:            is_clear  = 1'b0;
    endcase
  end

  // Store an appended character unless full or a repeated star
  assign room      = (count_r < CNT_W'(MAX_PATTERN));
  assign last_star = ~empty_r & (char_q[0] == wgm_pkg::STAR_CODE);
  assign store     = is_append & room &
                     ~((in_char_code == wgm_pkg::STAR_CODE) & last_star);

  assign ctrl.clear = is_clear;
  assign ctrl.shift = store;
  assign ctrl.rearm = is_clear | is_append | is_end;
  assign ctrl.step  = is_subj;
  assign ctrl.ch    = in_char_code;

  // Track logical length, overflow and the empty stored pattern
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    empty_nxt = empty_r;
    if (is_clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      empty_nxt = 1'b1;
    end else if (is_append) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (store) begin
        empty_nxt = 1'b0;
      end
    end
  end

  // Advance the end position, which sits past cell zero
  assign end_raw = ctrl.rearm ? empty_nxt : move[0];

  always_comb begin
    end_nxt = end_r;
    if (ctrl.rearm || ctrl.step) begin
      end_nxt = end_raw | fwd[0];
    end
  end

  // Load the result register on end of subject, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (is_end) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      empty_r     <= 1'b1;
      end_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      empty_r     <= empty_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_end) begin
      out_matched_r <= end_r;
      out_ovf_r     <= ovf_r;
    end
  end

  // Chain of cells; cell zero holds the last stored character
  assign move[MAX_PATTERN] = 1'b0;
  assign fwd[MAX_PATTERN]  = 1'b0;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [wgm_pkg::CHAR_W-1:0] prev_char;
    logic                       prev_first;

    if (k == 0) begin : g_head
      assign prev_char  = in_char_code;
      assign prev_first = empty_r;
    end else begin : g_link
      assign prev_char  = char_q[k-1];
      assign prev_first = first_vec[k-1];
    end

    wgm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_char  (prev_char),
      .prev_first (prev_first),
      .move_in    (move[k+1]),
      .fwd_in     (fwd[k+1]),
      .char_q     (char_q[k]),
      .first_q    (first_vec[k]),
      .move_out   (move[k]),
      .fwd_out    (fwd[k])
    );
  end

  assign out_valid              = out_valid_r;
  assign out_matched            = out_matched_r;
  assign out_pattern_overflowed = out_ovf_r;

  // Consistency checks
  `GLOB_ASSERT(a_first_onehot0, clk, rst_n, $onehot0(first_vec), "more than one start cell")
  `GLOB_ASSERT_IMPL(a_start_present, clk, rst_n, !empty_r, $onehot(first_vec), "no start cell")
  `GLOB_ASSERT(a_empty_count, clk, rst_n, empty_r == (count_r == '0), "empty flag out of step")
  `GLOB_ASSERT_IMPL(a_ovf_full, clk, rst_n, ovf_r, count_r == CNT_W'(MAX_PATTERN), "overflow below capacity")
  `GLOB_ASSERT_IMPL(a_result_src, clk, rst_n, $rose(out_valid_r), $past(is_end), "result without end request")

endmodule
